### rtl/stid_pkg.sv
// shared types and constants for the sorted table block
// operation and status codes, controller/datapath command and status structs
// no dependencies

package stid_pkg;

	localparam int DATA_W        = 32;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int INDEX_W       = 10;
	localparam int COUNT_OUT_W   = 11;
	localparam int DEPTH_DEFAULT = 1024;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_REPLACE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// table read address source
	typedef enum logic [1:0] {
		RA_INS   = 2'd0,
		RA_SCAN  = 2'd1,
		RA_INDEX = 2'd2
	} raddr_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       load;        // capture the accepted item, clear the scan pointers, set j to the count
		logic       rd_en;       // issue a table read
		raddr_sel_t rd_sel;
		logic       ins_shift;   // move entry j-1 up to j, step j down
		logic       ins_place;   // write the new value at j, count up
		logic       scan_step;   // compaction step on the entry just read
		logic       scan_commit; // take the compacted count, start insert there
		logic       res_load;    // load the output register
		status_t    res_status;
		logic       res_use_rd;  // result carries the read data
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic full;
		logic j_zero;
		logic less;
		logic i_end;
		logic found;
		logic idx_ok;
		logic out_free;
	} sts_t;

endpackage

### rtl/stid_ram.sv
// generic single write, single read port memory with registered read data
// no dependencies

module stid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/stid_dp.sv
// datapath of the sorted table: table memory, pointers, entry count, output register
// depends on stid_pkg and stid_ram

module stid_dp #(
	parameter int DEPTH = stid_pkg::DEPTH_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [stid_pkg::OP_W-1:0]              in_op,
	input  logic signed [stid_pkg::DATA_W-1:0]     in_key,
	input  logic signed [stid_pkg::DATA_W-1:0]     in_new,
	input  logic [stid_pkg::INDEX_W-1:0]           in_index,
	input  stid_pkg::cmd_t                         cmd,
	output stid_pkg::sts_t                         sts,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [stid_pkg::STATUS_W-1:0]          status,
	output logic [stid_pkg::COUNT_OUT_W-1:0]       entry_count,
	output logic signed [stid_pkg::DATA_W-1:0]     read_value
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > stid_pkg::INDEX_W) ? CW : stid_pkg::INDEX_W;

	// item registers
	stid_pkg::op_t                     op_q;
	logic signed [stid_pkg::DATA_W-1:0] key_q;
	logic signed [stid_pkg::DATA_W-1:0] new_q;
	logic [stid_pkg::INDEX_W-1:0]       idx_q;

	// control registers
	logic          use_new_q;
	logic          found_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] count_q;

	// output register
	logic                               out_valid_q;
	stid_pkg::status_t                  status_q;
	logic [stid_pkg::COUNT_OUT_W-1:0]   entry_count_q;
	logic signed [stid_pkg::DATA_W-1:0] read_value_q;

	// memory port signals
	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr;
	logic [stid_pkg::DATA_W-1:0]        ram_wdata;
	logic [AW-1:0]                      ram_raddr;
	logic [stid_pkg::DATA_W-1:0]        ram_rdata;

	logic signed [stid_pkg::DATA_W-1:0] rd_s;
	logic signed [stid_pkg::DATA_W-1:0] ins_val;
	logic                               less;
	logic                               match;
	logic [CW-1:0]                      j_dec;

	stid_ram #(
		.WIDTH(stid_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// compare and match on the entry just read
	always_comb begin
		rd_s    = $signed(ram_rdata);
		ins_val = use_new_q ? new_q : key_q;
		less    = ins_val < rd_s;
		match   = (rd_s == key_q) && ((op_q == stid_pkg::OP_DELETE) || !found_q);
		j_dec   = j_q - 1'b1;
	end

	// read address select
	always_comb begin
		unique case (cmd.rd_sel)
			stid_pkg::RA_INS:   ram_raddr = j_dec[AW-1:0];
			stid_pkg::RA_SCAN:  ram_raddr = i_q[AW-1:0];
			stid_pkg::RA_INDEX: ram_raddr = AW'(idx_q);
			default:            ram_raddr = '0;
		endcase
	end

	// write port: insert shift/place at j, compaction keeps go to w
	always_comb begin
		ram_we    = cmd.ins_shift | cmd.ins_place | (cmd.scan_step & !match);
		ram_waddr = cmd.scan_step ? w_q[AW-1:0] : j_q[AW-1:0];
		ram_wdata = cmd.ins_place ? ins_val : ram_rdata;
	end

	// status to the controller
	always_comb begin
		sts.op       = op_q;
		sts.full     = count_q == CW'(DEPTH);
		sts.j_zero   = j_q == '0;
		sts.less     = less;
		sts.i_end    = i_q == count_q;
		sts.found    = found_q;
		sts.idx_ok   = XW'(idx_q) < XW'(count_q);
		sts.out_free = !out_valid_q || !out_stall;
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= stid_pkg::op_t'(in_op);
			key_q <= in_key;
			new_q <= in_new;
			idx_q <= in_index;
		end
		if (cmd.res_load) begin
			status_q      <= cmd.res_status;
			entry_count_q <= stid_pkg::COUNT_OUT_W'(count_q);
			read_value_q  <= cmd.res_use_rd ? rd_s : '0;
		end
	end

	// pointers, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_new_q   <= 1'b0;
			found_q     <= 1'b0;
			i_q         <= '0;
			w_q         <= '0;
			j_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				use_new_q <= 1'b0;
				found_q   <= 1'b0;
				i_q       <= '0;
				w_q       <= '0;
				j_q       <= count_q;
			end
			if (cmd.ins_shift) begin
				j_q <= j_dec;
			end
			if (cmd.ins_place) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.scan_step) begin
				i_q <= i_q + 1'b1;
				if (match) begin
					found_q <= 1'b1;
				end else begin
					w_q <= w_q + 1'b1;
				end
			end
			if (cmd.scan_commit) begin
				count_q   <= w_q;
				j_q       <= w_q;
				use_new_q <= 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign read_value  = read_value_q;

	// count never passes the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// compaction write pointer never overtakes the read pointer
	a_w_behind: assert property (@(posedge clk) disable iff (!arst_n)
		w_q <= i_q)
		else $error("compaction write pointer ahead of read pointer");

	// placing a value adds exactly one entry
	a_place_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_place |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not add one entry");

endmodule

### rtl/stid_ctrl.sv
// controller of the sorted table: sequences insert, compaction scan and read
// depends on stid_pkg

module stid_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  stid_pkg::sts_t sts,
	output stid_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_INS_RD,
		S_INS_CMP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SCAN_END,
		S_FIN
	} state_t;

	state_t            state_q;
	state_t            state_d;
	stid_pkg::status_t res_status_q;
	stid_pkg::status_t res_status_d;
	logic              res_use_rd_q;
	logic              res_use_rd_d;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		res_status_d   = res_status_q;
		res_use_rd_d   = res_use_rd_q;
		cmd            = '0;
		cmd.res_status = res_status_q;
		cmd.res_use_rd = res_use_rd_q;

		unique case (state_q)
			S_IDLE: begin
				cmd.load     = in_valid;
				res_status_d = stid_pkg::ST_OK;
				res_use_rd_d = 1'b0;
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					stid_pkg::OP_INSERT: begin
						if (sts.full) begin
							res_status_d = stid_pkg::ST_FULL;
							state_d      = S_FIN;
						end else begin
							state_d = S_INS_RD;
						end
					end
					stid_pkg::OP_DELETE, stid_pkg::OP_REPLACE: begin
						state_d = S_SCAN_RD;
					end
					stid_pkg::OP_READ: begin
						if (sts.idx_ok) begin
							cmd.rd_en    = 1'b1;
							cmd.rd_sel   = stid_pkg::RA_INDEX;
							res_use_rd_d = 1'b1;
						end else begin
							res_status_d = stid_pkg::ST_RANGE;
						end
						state_d = S_FIN;
					end
					default: state_d = S_FIN;
				endcase
			end
			// walk down from the top, moving larger entries up one place
			S_INS_RD: begin
				if (sts.j_zero) begin
					cmd.ins_place = 1'b1;
					state_d       = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = stid_pkg::RA_INS;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (sts.less) begin
					cmd.ins_shift = 1'b1;
					state_d       = S_INS_RD;
				end else begin
					cmd.ins_place = 1'b1;
					state_d       = S_FIN;
				end
			end
			// compaction pass over all entries
			S_SCAN_RD: begin
				if (sts.i_end) begin
					state_d = S_SCAN_END;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = stid_pkg::RA_SCAN;
					state_d    = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				cmd.scan_step = 1'b1;
				state_d       = S_SCAN_RD;
			end
			S_SCAN_END: begin
				if (!sts.found) begin
					res_status_d = stid_pkg::ST_NOT_FOUND;
					state_d      = S_FIN;
				end else begin
					cmd.scan_commit = 1'b1;
					state_d = (sts.op == stid_pkg::OP_REPLACE) ? S_INS_RD : S_FIN;
				end
			end
			// wait for room in the output register
			S_FIN: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and registered result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= stid_pkg::ST_OK;
			res_use_rd_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_status_q <= res_status_d;
			res_use_rd_q <= res_use_rd_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

	// the insert walk never reads below entry zero
	a_ins_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.rd_sel == stid_pkg::RA_INS) |-> !sts.j_zero)
		else $error("insert read below entry zero");

	// a result is only loaded when the output register can take it
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result loaded over a waiting result");

endmodule

### rtl/sorted_table_insert_delete_update_top.sv
// Sorted table of up to DEPTH signed 32-bit values kept in ascending order in one
// single-port-read memory. Each item gives one result (status, entry count, read value).
// One item is worked at a time; the next item may be accepted while a result waits.
// An insert walks down from the top over the entries above the new value, a delete
// scans all entries, a replace does both, and a read takes one table read. Every
// entry moved or scanned needs a table read and then a compare/write step.
// No clearing pass after reset.
// depends on stid_pkg, stid_ctrl, stid_dp

module sorted_table_insert_delete_update_top #(
	parameter int DEPTH = stid_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [stid_pkg::OP_W-1:0]           op,
	input  logic signed [stid_pkg::DATA_W-1:0]  key_value,
	input  logic signed [stid_pkg::DATA_W-1:0]  new_value,
	input  logic [stid_pkg::INDEX_W-1:0]        index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [stid_pkg::STATUS_W-1:0]       status,
	output logic [stid_pkg::COUNT_OUT_W-1:0]    entry_count,
	output logic signed [stid_pkg::DATA_W-1:0]  read_value
);

	stid_pkg::cmd_t cmd;
	stid_pkg::sts_t sts;

	// sequencer
	stid_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// table, pointers and output register
	stid_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (op),
		.in_key     (key_value),
		.in_new     (new_value),
		.in_index   (index),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.entry_count(entry_count),
		.read_value (read_value)
	);

endmodule
